FILE: src/prac_pkg.sv
// Shared constants for the point rotation pipeline: CORDIC gain and arctangent table.
// Used by point_rotate_about_center; depends on nothing else.
package prac_pkg;

    localparam int PHASE_WIDTH = 32;
    localparam int MAX_STAGES  = 24;
    localparam int EXTRA_FRAC  = 16;

    // Inverse CORDIC gain in Q30.
    localparam logic signed [30:0] GAIN_Q30 = 31'sd652032874;

    localparam logic signed [PHASE_WIDTH-1:0] QUARTER_TURN = 32'sh4000_0000;

    // Arctangent of 2^-i in units of 2^-32 turn.
    localparam logic [PHASE_WIDTH-1:0] ATAN_TURNS [MAX_STAGES] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };

endpackage

FILE: src/point_rotate_about_center.sv
// Rotates a point about a center in screen coordinates with a pipelined CORDIC.
// Depends on prac_pkg for the gain constant and the arctangent table.
//
//   channel   direction  handshake           word
//   input     in         in_valid/in_stall   point_x, point_y, center_x, center_y,
//                                            rotation_angle
//   output    out        out_valid/out_stall rotated_x, rotated_y, saturated
//
// One word enters per cycle unless in_stall is high; there is one register per
// CORDIC iteration plus difference, multiply, scale, rounding and output stages.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stall on the output holds only the stages that are full up to the output,
// so empty stages keep filling and in_stall rises only when every stage is full.
module point_rotate_about_center #(
    parameter int COORD_WIDTH   = 24,
    parameter int ANGLE_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic signed [ANGLE_WIDTH-1:0] rotation_angle,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0] rotated_x,
    output logic signed [COORD_WIDTH-1:0] rotated_y,
    output logic                          saturated
);

    localparam int ZW    = prac_pkg::PHASE_WIDTH;
    localparam int N     = CORDIC_STAGES;
    localparam int DW    = COORD_WIDTH + 1;
    localparam int PW    = DW + 31;
    localparam int VW    = PW - (30 - prac_pkg::EXTRA_FRAC);
    localparam int W     = COORD_WIDTH + 19;
    localparam int RW    = W - prac_pkg::EXTRA_FRAC;
    localparam int SW    = COORD_WIDTH + 4;
    localparam int DEPTH = N + 5;
    localparam int ROUND_IDX = N + 3;
    localparam int OUT_IDX   = N + 4;

    localparam logic signed [SW-1:0] MAX_COORD = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] MIN_COORD = -MAX_COORD - SW'(1);

    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic [DEPTH-1:0] hold;
    logic [DEPTH-1:0] en;

    // Stage 0: differences and folded phase.
    logic signed [DW-1:0]          dx_reg, dy_reg, dx_next, dy_next;
    logic signed [COORD_WIDTH-1:0] cx0_reg, cy0_reg;
    logic signed [ZW-1:0]          z0_reg, z0_next, z_raw;
    logic                          neg0_reg, neg0_next;

    // Stage 1: gain products.
    logic signed [PW-1:0]          px_reg, py_reg, px_next, py_next;
    logic signed [COORD_WIDTH-1:0] cx1_reg, cy1_reg;
    logic signed [ZW-1:0]          z1_reg;
    logic                          neg1_reg;

    // CORDIC vectors; index 0 is the scaled start vector.
    logic signed [W-1:0]           x_reg  [N+1];
    logic signed [W-1:0]           y_reg  [N+1];
    logic signed [ZW-1:0]          z_reg  [N+1];
    logic signed [COORD_WIDTH-1:0] cx_reg [N+1];
    logic signed [COORD_WIDTH-1:0] cy_reg [N+1];

    logic signed [PW-1:0] psx, psy;
    logic signed [W-1:0]  vx, vy, x0_next, y0_next;

    // Rounding stage and output stage.
    logic signed [SW-1:0]          sx_reg, sy_reg, sx_next, sy_next;
    logic signed [W-1:0]           rsx, rsy;
    logic signed [RW-1:0]          rx, ry;
    logic signed [COORD_WIDTH-1:0] ox_reg, oy_reg, ox_next, oy_next;
    logic                          sat_reg, sat_next;

    // Handshake: a stage holds only when it and everything downstream is full.
    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_hold
            assign hold[k] = out_stall && (&vld_reg[DEPTH-1:k]);
            assign en[k]   = !hold[k];
            if (k == 0)
            begin : g_first
                assign vld_next[k] = en[k] ? in_valid : vld_reg[k];
            end
            else
            begin : g_rest
                assign vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
            end
        end
    endgenerate

    assign in_stall = hold[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 0.
    always_comb
    begin
        dx_next = DW'(point_x) - DW'(center_x);
        dy_next = DW'(center_y) - DW'(point_y);
        z_raw   = {rotation_angle, {(ZW - ANGLE_WIDTH){1'b0}}};
        neg0_next = (z_raw > prac_pkg::QUARTER_TURN) || (z_raw < -prac_pkg::QUARTER_TURN);
        z0_next = neg0_next ? {~z_raw[ZW-1], z_raw[ZW-2:0]} : z_raw;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            cx0_reg  <= center_x;
            cy0_reg  <= center_y;
            z0_reg   <= z0_next;
            neg0_reg <= neg0_next;
        end
    end

    // Stage 1.
    assign px_next = PW'(dx_reg) * PW'(prac_pkg::GAIN_Q30);
    assign py_next = PW'(dy_reg) * PW'(prac_pkg::GAIN_Q30);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            cx1_reg  <= cx0_reg;
            cy1_reg  <= cy0_reg;
            z1_reg   <= z0_reg;
            neg1_reg <= neg0_reg;
        end
    end

    // Stage 2: scale to 16 extra fraction bits, then apply the half-turn fold.
    always_comb
    begin
        psx = px_reg + PW'(1 <<< (29 - prac_pkg::EXTRA_FRAC));
        psy = py_reg + PW'(1 <<< (29 - prac_pkg::EXTRA_FRAC));
        vx  = {{(W - VW){psx[PW-1]}}, psx[PW-1:PW-VW]};
        vy  = {{(W - VW){psy[PW-1]}}, psy[PW-1:PW-VW]};
        x0_next = neg1_reg ? -vx : vx;
        y0_next = neg1_reg ? -vy : vy;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            x_reg[0]  <= x0_next;
            y_reg[0]  <= y0_next;
            z_reg[0]  <= z1_reg;
            cx_reg[0] <= cx1_reg;
            cy_reg[0] <= cy1_reg;
        end
    end

    // CORDIC iterations, one register stage each.
    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cordic
            logic signed [W-1:0]  xs, ys, x_next, y_next;
            logic signed [ZW-1:0] z_next;

            always_comb
            begin
                xs = x_reg[i] >>> i;
                ys = y_reg[i] >>> i;
                if (!z_reg[i][ZW-1])
                begin
                    x_next = x_reg[i] - ys;
                    y_next = y_reg[i] + xs;
                    z_next = z_reg[i] - $signed(prac_pkg::ATAN_TURNS[i]);
                end
                else
                begin
                    x_next = x_reg[i] + ys;
                    y_next = y_reg[i] - xs;
                    z_next = z_reg[i] + $signed(prac_pkg::ATAN_TURNS[i]);
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[i+3])
                begin
                    x_reg[i+1]  <= x_next;
                    y_reg[i+1]  <= y_next;
                    z_reg[i+1]  <= z_next;
                    cx_reg[i+1] <= cx_reg[i];
                    cy_reg[i+1] <= cy_reg[i];
                end
            end
        end
    endgenerate

    // Round to whole units and move back to screen coordinates.
    always_comb
    begin
        rsx = x_reg[N] + W'(1 <<< (prac_pkg::EXTRA_FRAC - 1));
        rsy = y_reg[N] + W'(1 <<< (prac_pkg::EXTRA_FRAC - 1));
        rx  = rsx[W-1:prac_pkg::EXTRA_FRAC];
        ry  = rsy[W-1:prac_pkg::EXTRA_FRAC];
        sx_next = SW'(cx_reg[N]) + SW'(rx);
        sy_next = SW'(cy_reg[N]) - SW'(ry);
    end

    always_ff @(posedge clk)
    begin
        if (en[ROUND_IDX])
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
    end

    // Clamp to the coordinate range.
    always_comb
    begin
        sat_next = 1'b0;
        if (sx_reg > MAX_COORD)
        begin
            ox_next  = COORD_WIDTH'(MAX_COORD);
            sat_next = 1'b1;
        end
        else if (sx_reg < MIN_COORD)
        begin
            ox_next  = COORD_WIDTH'(MIN_COORD);
            sat_next = 1'b1;
        end
        else
        begin
            ox_next  = COORD_WIDTH'(sx_reg);
        end
        if (sy_reg > MAX_COORD)
        begin
            oy_next  = COORD_WIDTH'(MAX_COORD);
            sat_next = 1'b1;
        end
        else if (sy_reg < MIN_COORD)
        begin
            oy_next  = COORD_WIDTH'(MIN_COORD);
            sat_next = 1'b1;
        end
        else
        begin
            oy_next  = COORD_WIDTH'(sy_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[OUT_IDX])
        begin
            ox_reg  <= ox_next;
            oy_reg  <= oy_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = vld_reg[OUT_IDX];
    assign rotated_x = ox_reg;
    assign rotated_y = oy_reg;
    assign saturated = sat_reg;

    // The input is refused only when every stage holds a word.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&vld_reg))
        else $error("input stalled while the pipeline has an empty stage");

    // An accepted word always lands in the first stage.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[0])
        else $error("accepted word did not reach the first stage");

    // After the half-turn fold the phase lies within a quarter turn.
    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> ((z0_reg <= prac_pkg::QUARTER_TURN) &&
                        (z0_reg >= -prac_pkg::QUARTER_TURN)))
        else $error("folded phase out of range");

    // A word waiting at the output while stalled is neither lost nor replaced.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(ox_reg) && $stable(oy_reg)))
        else $error("stalled output word changed");

endmodule
